// ===== hdl/ilir_pkg.sv =====
// Shared constants, request codes and the command struct for the indexed list engine.
package ilir_pkg;

	localparam int DEPTH   = 64;
	localparam int ELEM_W  = 64;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int GROUP   = 8;
	localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

	localparam int REQ_W   = 3;
	localparam int POS_W   = 6;
	localparam int WORD_W  = 64;
	localparam int STAT_W  = 2;
	localparam int CAFT_W  = 7;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_GET    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_REM  = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pos;
		logic [ELEM_W-1:0] word;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} cmd_t;

endpackage

// ===== hdl/ilir_cell.sv =====
// One list slot: shifts with its neighbors on insert and remove, drives its word when read.
module ilir_cell (
	input  logic                      clk,
	input  ilir_pkg::cmd_t            cmd,
	input  logic [ilir_pkg::IDX_W-1:0]  idx,
	input  logic [ilir_pkg::ELEM_W-1:0] left,
	input  logic [ilir_pkg::ELEM_W-1:0] right,
	output logic [ilir_pkg::ELEM_W-1:0] word,
	output logic [ilir_pkg::ELEM_W-1:0] rd
);
	import ilir_pkg::*;

	logic [ELEM_W-1:0] word_q;
	logic [ELEM_W-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (cmd.op)
			OP_INS: begin
				if (idx > cmd.pos) begin
					word_d = left;
				end else if (idx == cmd.pos) begin
					word_d = cmd.word;
				end
			end
			OP_REM: begin
				if (idx >= cmd.pos) begin
					word_d = right;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
	assign rd   = (cmd.rd_en && idx == cmd.rd_idx) ? word_q : '0;

endmodule

// ===== hdl/indexed_list_insert_remove.sv =====
// Top level of the indexed list engine: request decode, the row of slot cells, read tree.
// Ordered list of up to DEPTH words held in a row of cells, one word per cell. A request
// is taken in every cycle that the output side does not stall: push, insert and remove
// move each affected cell to its neighbor's word or the new word in that same cycle,
// so the list is updated at the accepting edge and the next request sees it. Pop and
// get read the selected cell through a two-level OR tree that is registered after
// groups of GROUP cells and again at the output. A stalled output holds the whole
// path and raises in_stall. No clearing pass is needed after reset; only slots below
// the length are ever read.
module indexed_list_insert_remove (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ilir_pkg::REQ_W-1:0]  req_type,
	input  logic [ilir_pkg::POS_W-1:0]  position,
	input  logic [ilir_pkg::WORD_W-1:0] element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ilir_pkg::WORD_W-1:0] read_value,
	output logic [ilir_pkg::STAT_W-1:0] status,
	output logic [ilir_pkg::CAFT_W-1:0] count_after
);
	import ilir_pkg::*;

	logic             en;
	logic             acc;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] posx;
	logic [STAT_W-1:0] stat_d;
	logic             full;
	cmd_t             cmd_d;
	cmd_t             cmd;

	logic [ELEM_W-1:0] words [DEPTH];
	logic [ELEM_W-1:0] rds   [DEPTH];
	logic [ELEM_W-1:0] grp_d [NGROUP];
	logic [ELEM_W-1:0] grp_s1 [NGROUP];
	logic              valid_s1;
	logic [STAT_W-1:0] stat_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic [ELEM_W-1:0] rd_all;

	logic              valid_q;
	logic [ELEM_W-1:0] value_q;
	logic [STAT_W-1:0] stat_q;
	logic [CNT_W-1:0]  cnt_q;

	// advance the whole path unless a finished result is held back
	assign en       = !(valid_q && out_stall);
	assign in_stall = !en;
	assign acc      = in_valid && en;

	assign posx = CNT_W'(position);
	assign full = count_q >= CNT_W'(DEPTH);

	always_comb begin
		cmd_d        = '0;
		cmd_d.word   = element[ELEM_W-1:0];
		cmd_d.pos    = IDX_W'(position);
		cmd_d.rd_idx = IDX_W'(position);
		count_d      = count_q;
		stat_d       = ST_OK;
		case (req_type)
			REQ_PUSH: begin
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					cmd_d.op  = OP_INS;
					cmd_d.pos = count_q[IDX_W-1:0];
					count_d   = count_q + CNT_W'(1);
				end
			end
			REQ_POP: begin
				if (count_q == '0) begin
					stat_d = ST_RANGE;
				end else begin
					cmd_d.rd_en  = 1'b1;
					cmd_d.rd_idx = IDX_W'(count_q - CNT_W'(1));
					count_d      = count_q - CNT_W'(1);
				end
			end
			REQ_INSERT: begin
				if (full) begin
					stat_d = ST_FULL;
				end else if (posx > count_q) begin
					stat_d = ST_RANGE;
				end else begin
					cmd_d.op = OP_INS;
					count_d  = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (posx >= count_q) begin
					stat_d = ST_RANGE;
				end else begin
					cmd_d.op = OP_REM;
					count_d  = count_q - CNT_W'(1);
				end
			end
			REQ_GET: begin
				if (posx >= count_q) begin
					stat_d = ST_RANGE;
				end else begin
					cmd_d.rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// drop the command unless the transaction is taken
	always_comb begin
		cmd = cmd_d;
		if (!acc) begin
			cmd.op    = OP_NONE;
			cmd.rd_en = 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEM_W-1:0] left_w;
		logic [ELEM_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end
		ilir_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (IDX_W'(i)),
			.left  (left_w),
			.right (right_w),
			.word  (words[i]),
			.rd    (rds[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGROUP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < DEPTH) begin
					grp_d[g] = grp_d[g] | rds[g * GROUP + k];
				end
			end
		end
	end

	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NGROUP; g++) begin
			rd_all = rd_all | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_q  <= valid_s1;
			if (acc) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s1  <= grp_d;
			stat_s1 <= stat_d;
			cnt_s1  <= count_d;
			value_q <= rd_all;
			stat_q  <= stat_s1;
			cnt_q   <= cnt_s1;
		end
	end

	assign out_valid   = valid_q;
	assign read_value  = WORD_W'(value_q);
	assign status      = stat_q;
	assign count_after = CAFT_W'(cnt_q);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the indexed list engine: queued requests, list predictor, result checks.
module testbench;
	import ilir_pkg::*;

	localparam logic [REQ_W-1:0] REQ_LENGTH = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_FROM   = 250;
	localparam int QUIET_TO     = 400;
	localparam int HOLD_AT      = 450;
	localparam int HOLD_CYCLES  = 120;

	typedef struct {
		logic [REQ_W-1:0]  kind;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} list_request_t;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic [STAT_W-1:0] stat;
		logic [CAFT_W-1:0] len;
	} list_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [POS_W-1:0] position = '0;
	logic [WORD_W-1:0] element = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] read_value;
	logic [STAT_W-1:0] status;
	logic [CAFT_W-1:0] count_after;

	list_request_t pending_requests[$];
	list_answer_t expected_answers[$];
	logic [WORD_W-1:0] list_words[DEPTH];
	int list_len = 0;
	int gen_len = 0;
	int taken_count = 0;
	int mismatches = 0;
	logic in_busy = 1'b0;
	logic stall_hold = 1'b0;
	logic quiet;

	indexed_list_insert_remove DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.element(element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.status(status),
		.count_after(count_after)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	assign quiet = (taken_count >= QUIET_FROM) && (taken_count < QUIET_TO);

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Queue a request and track the length it leaves, so positions can aim inside the list.
	function automatic void queue_request(input logic [REQ_W-1:0] kind,
		input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word);
		list_request_t req;
		req.kind = kind;
		req.pos = pos;
		req.word = word;
		pending_requests.push_back(req);
		case (kind)
			REQ_PUSH: if (gen_len < DEPTH) gen_len++;
			REQ_POP: if (gen_len > 0) gen_len--;
			REQ_INSERT: if (gen_len < DEPTH && pos <= gen_len) gen_len++;
			REQ_REMOVE: if (pos < gen_len) gen_len--;
			default: ;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		int pick;
		pick = $urandom_range(7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [POS_W-1:0] pos_in_list();
		if (gen_len == 0)
			return POS_W'($urandom_range(63));
		return POS_W'($urandom_range(gen_len - 1));
	endfunction

	// Apply one accepted transaction to the shadow list and queue the answer it must produce.
	function automatic void predict_request(input logic [REQ_W-1:0] kind,
		input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word);
		list_answer_t ans;
		ans.value = '0;
		ans.stat = ST_OK;
		case (kind)
			REQ_PUSH: begin
				if (list_len >= DEPTH) begin
					ans.stat = ST_FULL;
				end else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			REQ_POP: begin
				if (list_len == 0) begin
					ans.stat = ST_RANGE;
				end else begin
					list_len--;
					ans.value = list_words[list_len];
				end
			end
			REQ_INSERT: begin
				if (list_len >= DEPTH) begin
					ans.stat = ST_FULL;
				end else if (pos > list_len) begin
					ans.stat = ST_RANGE;
				end else begin
					for (int i = list_len; i > pos; i--)
						list_words[i] = list_words[i - 1];
					list_words[pos] = word;
					list_len++;
				end
			end
			REQ_REMOVE: begin
				if (pos >= list_len) begin
					ans.stat = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			REQ_GET: begin
				if (pos >= list_len)
					ans.stat = ST_RANGE;
				else
					ans.value = list_words[pos];
			end
			default: ;
		endcase
		ans.len = list_len[CAFT_W-1:0];
		expected_answers.push_back(ans);
	endfunction

	// Sender: hold a stalled transaction, otherwise offer the next pending request or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_busy) begin
			if (pending_requests.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
				in_valid <= 1'b1;
				req_type <= pending_requests[0].kind;
				position <= pending_requests[0].pos;
				element <= pending_requests[0].word;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, none in the quiet window, solid during the hold-off.
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= stall_hold || (!quiet && $urandom_range(99) < 21);
	end

	initial begin
		wait (taken_count >= HOLD_AT);
		@(negedge clk);
		stall_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		stall_hold <= 1'b0;
	end

	always @(posedge clk) begin : monitor
		list_answer_t ans;
		if (!arst_n) begin
			in_busy <= 1'b0;
		end else begin
			in_busy <= in_valid && in_stall;
			if (in_valid && !in_stall) begin
				predict_request(req_type, position, element);
				pending_requests.delete(0);
				taken_count++;
			end
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					ans = expected_answers.pop_front();
					if (read_value !== ans.value)
						report_mismatch($sformatf("read_value %h, want %h",
							read_value, ans.value));
					if (status !== ans.stat)
						report_mismatch($sformatf("status %0d, want %0d", status, ans.stat));
					if (count_after !== ans.len)
						report_mismatch($sformatf("count_after %0d, want %0d",
							count_after, ans.len));
				end
			end
		end
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int seg;
		int seg_count;
		int pick;
		int random_target;

		// empty list corners, then a short list worked from both ends
		queue_request(REQ_LENGTH, 6'd0, '0);
		queue_request(REQ_POP, 6'd0, '0);
		queue_request(REQ_GET, 6'd0, '0);
		queue_request(REQ_REMOVE, 6'd63, '1);
		queue_request(REQ_INSERT, 6'd1, 64'h1111_2222_3333_4444);
		queue_request(REQ_INSERT, 6'd0, '1);
		queue_request(REQ_PUSH, 6'd63, '0);
		queue_request(REQ_INSERT, 6'd2, 64'hA5A5_A5A5_5A5A_5A5A);
		queue_request(REQ_INSERT, 6'd1, 64'h0123_4567_89AB_CDEF);
		queue_request(REQ_GET, 6'd0, '0);
		queue_request(REQ_GET, 6'd3, '0);
		queue_request(REQ_GET, 6'd4, '0);
		queue_request(REQ_GET, 6'd63, '0);
		queue_request(REQ_REMOVE, 6'd1, '0);
		queue_request(REQ_REMOVE, 6'd2, '0);
		queue_request(REQ_REMOVE, 6'd2, '0);
		queue_request(REQ_POP, 6'd0, '0);
		queue_request(REQ_SPARE6, 6'd63, '1);
		queue_request(REQ_SPARE7, 6'd42, 64'hDEAD_BEEF_0BAD_F00D);
		queue_request(REQ_PUSH, 6'd0, '1);
		queue_request(REQ_POP, 6'd0, '0);
		queue_request(REQ_POP, 6'd0, '0);
		queue_request(REQ_POP, 6'd0, '0);

		// fill and drain first, then mix segments at random
		random_target = pending_requests.size() + RANDOM_ITEMS;
		seg_count = 0;
		while (pending_requests.size() < random_target) begin
			seg = (seg_count < 2) ? seg_count : $urandom_range(3);
			seg_count++;
			case (seg)
				0: begin
					while (gen_len < DEPTH) begin
						pick = $urandom_range(9);
						if (pick < 5)
							queue_request(REQ_PUSH, POS_W'($urandom_range(63)), random_word());
						else if (pick < 9)
							queue_request(REQ_INSERT, POS_W'($urandom_range(gen_len)),
								random_word());
						else
							queue_request(REQ_GET, pos_in_list(), random_word());
					end
					repeat ($urandom_range(4, 1))
						queue_request($urandom_range(1) ? REQ_PUSH : REQ_INSERT,
							POS_W'($urandom_range(63)), random_word());
				end
				1: begin
					while (gen_len > 0) begin
						pick = $urandom_range(9);
						if (pick < 4)
							queue_request(REQ_POP, POS_W'($urandom_range(63)), random_word());
						else if (pick < 8)
							queue_request(REQ_REMOVE, pos_in_list(), random_word());
						else
							queue_request(REQ_GET, pos_in_list(), random_word());
					end
					repeat ($urandom_range(3, 1)) begin
						pick = $urandom_range(2);
						queue_request(pick == 0 ? REQ_POP : (pick == 1 ? REQ_REMOVE : REQ_GET),
							POS_W'($urandom_range(63)), random_word());
					end
				end
				2: begin
					repeat (40) begin
						pick = $urandom_range(5);
						if (pick == 2 && $urandom_range(4) != 0)
							queue_request(REQ_INSERT, POS_W'($urandom_range(gen_len)),
								random_word());
						else if ((pick == 3 || pick == 4) && $urandom_range(4) != 0)
							queue_request(pick == 3 ? REQ_REMOVE : REQ_GET, pos_in_list(),
								random_word());
						else
							queue_request(REQ_W'(pick), POS_W'($urandom_range(63)),
								random_word());
					end
				end
				default: begin
					repeat (8)
						queue_request(REQ_W'($urandom_range(7)), POS_W'($urandom_range(63)),
							random_word());
				end
			endcase
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_answers.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
